/* sv/qaer_pkg.sv */
// Shared types and constants for the queue with alternate entry removal.
package qaer_pkg;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned CountW     = 6;
  localparam int unsigned ValueW     = 32;

  typedef enum logic [1:0] {
    OpPush  = 2'd0,
    OpHalve = 2'd1,
    OpList  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StHalve,
    StListRd,
    StListEmit,
    StResult
  } state_e;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [ValueW-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] item_value;
    logic [CountW-1:0]        entry_count;
    logic [1:0]               status;
    logic                     last_of_run;
  } out_t;

endpackage

/* sv/queue_with_alternate_entry_removal.sv */
// Top level: bounded queue with push, alternate entry removal and listing.
// Push and unused codes: the result is held in the core's result state, then in the output register.
// Halve: one store read and write per kept entry past the head. List: a read state and an emit
// state per entry through the single store read port. A stalled output holds the sequencer.
// Reset clears the fill count and control state; store contents stay undefined, no clear pass.
module queue_with_alternate_entry_removal (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qaer_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qaer_pkg::out_t out_data_o
);

  logic           res_valid;
  logic           res_ready;
  qaer_pkg::out_t res_data;
  logic           out_valid_q;
  qaer_pkg::out_t out_data_q;

  qaer_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* sv/qaer_core.sv */
// Entry store, fill count and operation sequencer of the queue.
module qaer_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qaer_pkg::in_t  in_data_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output qaer_pkg::out_t res_data_o
);

  qaer_pkg::state_e state_q, state_d;

  logic signed [qaer_pkg::ValueW-1:0] mem_q [qaer_pkg::QueueDepth];
  logic signed [qaer_pkg::ValueW-1:0] rd_data_q;

  logic [qaer_pkg::CntW-1:0] count_q, count_d;
  logic [qaer_pkg::IdxW-1:0] idx_q, idx_d;
  logic [qaer_pkg::IdxW-1:0] wr_idx_q, wr_idx_d;
  logic                      wr_pend_q, wr_pend_d;
  qaer_pkg::out_t            res_q, res_d;

  logic                               in_xfer;
  logic                               full;
  logic                               last;
  logic [qaer_pkg::CntW:0]            cnt_inc;
  logic [qaer_pkg::CntW-1:0]          kept;
  logic                               wr_en;
  logic [qaer_pkg::IdxW-1:0]          wr_addr;
  logic signed [qaer_pkg::ValueW-1:0] wr_data;
  logic                               rd_en;
  logic [qaer_pkg::IdxW-1:0]          rd_addr;

  assign in_xfer = in_valid_i && in_ready_o;
  assign full    = count_q == qaer_pkg::CntW'(qaer_pkg::QueueDepth);
  assign last    = (qaer_pkg::CntW'(idx_q) + qaer_pkg::CntW'(1)) == count_q;
  assign cnt_inc = {1'b0, count_q} + (qaer_pkg::CntW + 1)'(1);
  assign kept    = cnt_inc[qaer_pkg::CntW:1];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      qaer_pkg::StIdle: begin
        if (in_valid_i) begin
          unique case (in_data_i.func)
            qaer_pkg::OpHalve: begin
              state_d = (kept < qaer_pkg::CntW'(2)) ? qaer_pkg::StResult : qaer_pkg::StHalve;
            end
            qaer_pkg::OpList: begin
              state_d = (count_q == '0) ? qaer_pkg::StResult : qaer_pkg::StListRd;
            end
            default: begin
              state_d = qaer_pkg::StResult;
            end
          endcase
        end
      end
      qaer_pkg::StHalve: begin
        if (last) begin
          state_d = qaer_pkg::StResult;
        end
      end
      qaer_pkg::StListRd: begin
        state_d = qaer_pkg::StListEmit;
      end
      qaer_pkg::StListEmit: begin
        if (res_ready_i) begin
          state_d = last ? qaer_pkg::StIdle : qaer_pkg::StListRd;
        end
      end
      qaer_pkg::StResult: begin
        if (res_ready_i) begin
          state_d = qaer_pkg::StIdle;
        end
      end
      default: begin
        state_d = qaer_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o  = state_q == qaer_pkg::StIdle;
    res_valid_o = (state_q == qaer_pkg::StResult) || (state_q == qaer_pkg::StListEmit);
    rd_en       = (state_q == qaer_pkg::StHalve) || (state_q == qaer_pkg::StListRd);
    rd_addr     = (state_q == qaer_pkg::StHalve) ? {idx_q[qaer_pkg::IdxW-2:0], 1'b0} : idx_q;
    wr_en       = wr_pend_q ||
                  (in_xfer && (in_data_i.func == qaer_pkg::OpPush) && !full);
    wr_addr     = wr_pend_q ? wr_idx_q : count_q[qaer_pkg::IdxW-1:0];
    wr_data     = wr_pend_q ? rd_data_q : in_data_i.value;
    if (state_q == qaer_pkg::StListEmit) begin
      res_data_o.item_value  = rd_data_q;
      res_data_o.entry_count = qaer_pkg::CountW'(count_q);
      res_data_o.status      = qaer_pkg::StatOk;
      res_data_o.last_of_run = last;
    end else begin
      res_data_o = res_q;
    end
  end

  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    wr_idx_d  = wr_idx_q;
    wr_pend_d = 1'b0;
    res_d     = res_q;
    if (in_xfer) begin
      res_d.item_value  = '0;
      res_d.entry_count = qaer_pkg::CountW'(count_q);
      res_d.status      = qaer_pkg::StatOk;
      res_d.last_of_run = 1'b1;
      unique case (in_data_i.func)
        qaer_pkg::OpPush: begin
          if (full) begin
            res_d.status = qaer_pkg::StatFull;
          end else begin
            count_d           = cnt_inc[qaer_pkg::CntW-1:0];
            res_d.entry_count = qaer_pkg::CountW'(cnt_inc[qaer_pkg::CntW-1:0]);
          end
        end
        qaer_pkg::OpHalve: begin
          count_d           = kept;
          idx_d             = qaer_pkg::IdxW'(1);
          res_d.entry_count = qaer_pkg::CountW'(kept);
        end
        qaer_pkg::OpList: begin
          idx_d = '0;
          if (count_q == '0) begin
            res_d.status = qaer_pkg::StatEmpty;
          end
        end
        default: begin
        end
      endcase
    end
    if (state_q == qaer_pkg::StHalve) begin
      wr_pend_d = 1'b1;
      wr_idx_d  = idx_q;
      idx_d     = idx_q + qaer_pkg::IdxW'(1);
    end
    if ((state_q == qaer_pkg::StListEmit) && res_ready_i) begin
      idx_d = idx_q + qaer_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= qaer_pkg::StIdle;
      count_q   <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      wr_pend_q <= wr_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    wr_idx_q <= wr_idx_d;
    res_q    <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

endmodule

/* verif/tb_queue_with_alternate_entry_removal.sv */
// Testbench for the alternate-removal queue: scoreboard prediction under random traffic.
module tb_queue_with_alternate_entry_removal;

  localparam logic [1:0] OpUnused    = 2'd3;
  localparam int unsigned TotalItems  = 210;
  localparam int unsigned PhaseItems  = 70;
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned DrainCycles = 80;
  localparam int unsigned ShownLimit  = 10;

  class queue_scoreboard;
    logic signed [qaer_pkg::ValueW-1:0] entries[qaer_pkg::QueueDepth];
    int unsigned entry_total;
    qaer_pkg::out_t awaited_results[$];
    int unsigned failures;

    function qaer_pkg::out_t make_result(logic [qaer_pkg::ValueW-1:0] value,
                                         logic [1:0] status, logic last);
      qaer_pkg::out_t r;
      r.item_value  = value;
      r.entry_count = qaer_pkg::CountW'(entry_total);
      r.status      = status;
      r.last_of_run = last;
      return r;
    endfunction

    function void note_transfer(qaer_pkg::in_t item);
      int unsigned kept;
      int unsigned i;
      case (item.func)
        qaer_pkg::OpPush: begin
          if (entry_total >= qaer_pkg::QueueDepth) begin
            awaited_results.push_back(make_result('0, qaer_pkg::StatFull, 1'b1));
          end else begin
            entries[entry_total] = item.value;
            entry_total++;
            awaited_results.push_back(make_result('0, qaer_pkg::StatOk, 1'b1));
          end
        end
        qaer_pkg::OpHalve: begin
          kept = (entry_total + 1) / 2;
          for (i = 1; i < kept; i++) entries[i] = entries[2 * i];
          entry_total = kept;
          awaited_results.push_back(make_result('0, qaer_pkg::StatOk, 1'b1));
        end
        qaer_pkg::OpList: begin
          if (entry_total == 0) begin
            awaited_results.push_back(make_result('0, qaer_pkg::StatEmpty, 1'b1));
          end else begin
            for (i = 0; i < entry_total; i++)
              awaited_results.push_back(make_result(entries[i], qaer_pkg::StatOk,
                                                    i + 1 == entry_total));
          end
        end
        default: begin
          awaited_results.push_back(make_result('0, qaer_pkg::StatOk, 1'b1));
        end
      endcase
    endfunction

    function void report(string what, qaer_pkg::out_t want, qaer_pkg::out_t got);
      failures++;
      if (failures <= ShownLimit) begin
        $display("%s: expected value %0d count %0d status %0d last %0b", what,
                 want.item_value, want.entry_count, want.status, want.last_of_run);
        $display("%s:   actual value %0d count %0d status %0d last %0b", what,
                 got.item_value, got.entry_count, got.status, got.last_of_run);
      end
    endfunction

    function void check_result(qaer_pkg::out_t got);
      qaer_pkg::out_t want;
      if (awaited_results.size() == 0) begin
        want = '0;
        report("unexpected result", want, got);
        return;
      end
      want = awaited_results.pop_front();
      if (got.item_value !== want.item_value || got.entry_count !== want.entry_count ||
          got.status !== want.status || got.last_of_run !== want.last_of_run)
        report("mismatch", want, got);
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  qaer_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  qaer_pkg::out_t out_data;

  queue_scoreboard board = new();
  int unsigned sent_items = 0;
  int unsigned send_idle_pct = 35;
  int unsigned recv_stall_pct = 51;
  int unsigned cycle_count = 0;

  queue_with_alternate_entry_removal dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #5 clk = ~clk;

  task automatic send_item(input logic [1:0] func, input logic [qaer_pkg::ValueW-1:0] value);
    qaer_pkg::in_t item;
    item.func  = func;
    item.value = value;
    if (sent_items < PhaseItems) begin
      send_idle_pct  = 35;
      recv_stall_pct = 51;
    end else if (sent_items < 2 * PhaseItems) begin
      send_idle_pct  = 51;
      recv_stall_pct = 35;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    board.note_transfer(item);
    sent_items++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    rst_n     <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(qaer_pkg::OpList, 32'h1234_5678);
    send_item(qaer_pkg::OpHalve, 32'hffff_ffff);
    send_item(OpUnused, 32'h0000_0000);
    send_item(qaer_pkg::OpPush, 32'h8000_0000);
    send_item(qaer_pkg::OpPush, 32'h7fff_ffff);
    send_item(qaer_pkg::OpPush, 32'h0000_0000);
    send_item(qaer_pkg::OpPush, 32'hffff_ffff);
    send_item(qaer_pkg::OpPush, 32'h5555_5555);
    send_item(qaer_pkg::OpPush, 32'haaaa_aaaa);
    send_item(OpUnused, 32'hdead_beef);
    send_item(qaer_pkg::OpList, 32'h0000_0000);
    send_item(qaer_pkg::OpHalve, 32'h0000_0000);
    send_item(qaer_pkg::OpList, 32'hffff_ffff);
    send_item(qaer_pkg::OpPush, 32'h0000_0001);
    send_item(qaer_pkg::OpHalve, 32'h8000_0000);
    send_item(qaer_pkg::OpList, 32'h0000_0000);
    send_item(qaer_pkg::OpHalve, 32'h7fff_ffff);
    send_item(qaer_pkg::OpHalve, 32'h0000_0000);
    send_item(qaer_pkg::OpList, 32'h0000_0000);
    send_item(qaer_pkg::OpPush, 32'hc3c3_3c3c);
    send_item(qaer_pkg::OpList, 32'h0000_0000);

    while (sent_items < TotalItems) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        repeat ($urandom_range(1, 12)) send_item(qaer_pkg::OpPush, $urandom);
      end else if (pick < 50) begin
        while (board.entry_total < qaer_pkg::QueueDepth) send_item(qaer_pkg::OpPush, $urandom);
        repeat ($urandom_range(1, 3)) send_item(qaer_pkg::OpPush, $urandom);
        send_item(qaer_pkg::OpList, $urandom);
      end else if (pick < 68) begin
        send_item(qaer_pkg::OpHalve, $urandom);
      end else if (pick < 88) begin
        send_item(qaer_pkg::OpList, $urandom);
      end else begin
        send_item(2'($urandom_range(3)), $urandom);
      end
    end
    in_valid <= 1'b0;

    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    if (board.failures == 0 && board.awaited_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/qaer_pkg.sv
sv/qaer_core.sv
sv/queue_with_alternate_entry_removal.sv
verif/tb_queue_with_alternate_entry_removal.sv
